// ----- rtl/eight_bit_cpu_alu_with_flags_assert.svh -----
// ----------------------------------------------------------------------------
// ALU assertion macros
// Shared wrappers for concurrent assertions clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef EIGHT_BIT_CPU_ALU_WITH_FLAGS_ASSERT_SVH
`define EIGHT_BIT_CPU_ALU_WITH_FLAGS_ASSERT_SVH

// Check a property outside reset
`define EALU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property at every edge, reset included
`define EALU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/ealu_pkg.sv -----
// ----------------------------------------------------------------------------
// ALU package
// Opcodes, flag layout, BCD constants and the stage payload types.
// ----------------------------------------------------------------------------
package ealu_pkg;

  // Operation codes; codes above OP_SWAP leave everything unchanged
  typedef enum logic [4:0] {
    OP_ADD   = 5'd0,
    OP_ADC   = 5'd1,
    OP_SUB   = 5'd2,
    OP_SBC   = 5'd3,
    OP_AND   = 5'd4,
    OP_OR    = 5'd5,
    OP_XOR   = 5'd6,
    OP_CP    = 5'd7,
    OP_INC   = 5'd8,
    OP_DEC   = 5'd9,
    OP_ADD16 = 5'd10,
    OP_INC16 = 5'd11,
    OP_DEC16 = 5'd12,
    OP_DAA   = 5'd13,
    OP_RLC   = 5'd14,
    OP_RL    = 5'd15,
    OP_RRC   = 5'd16,
    OP_RR    = 5'd17,
    OP_SLA   = 5'd18,
    OP_SRA   = 5'd19,
    OP_SRL   = 5'd20,
    OP_BIT   = 5'd21,
    OP_SET   = 5'd22,
    OP_RES   = 5'd23,
    OP_SWAP  = 5'd24
  } op_e;

  // Flag bit positions
  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  // Decimal adjust limits and corrections
  localparam logic [7:0] DaaHiLimit = 8'h99;
  localparam logic [3:0] DaaLoLimit = 4'h9;
  localparam logic [7:0] DaaHiCorr  = 8'h60;
  localparam logic [7:0] DaaLoCorr  = 8'h06;

  // How the zero flag is formed in the last stage
  typedef enum logic [1:0] {
    Z_TEST,
    Z_KEEP,
    Z_CLEAR
  } zsel_e;

  // Captured operands plus early decode
  typedef struct packed {
    op_e         op;
    logic [7:0]  acc;
    logic [15:0] pair;
    logic [7:0]  val;
    logic [15:0] word;
    logic [7:0]  mask;
    logic        noz;
    logic [3:0]  flags;
    logic        cy;
    logic [7:0]  daa_corr;
    logic        daa_c;
  } prep_t;

  // Results with flag parts, before zero detection
  typedef struct packed {
    logic [7:0]  acc;
    logic [15:0] pair;
    logic [7:0]  byte_res;
    logic [15:0] word_res;
    logic [7:0]  zval;
    zsel_e       zsel;
    logic        zin;
    logic        n;
    logic        h;
    logic        c;
  } arith_t;

endpackage

// ----- rtl/ealu_prep.sv -----
// ----------------------------------------------------------------------------
// ALU operand stage
// Captures an input transfer, forms carry-in, bit mask and BCD correction.
// ----------------------------------------------------------------------------
module ealu_prep (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            stall_o,
  input  logic [4:0]      opcode_i,
  input  logic [7:0]      acc_in_i,
  input  logic [15:0]     pair_in_i,
  input  logic [7:0]      operand_byte_i,
  input  logic [15:0]     operand_word_i,
  input  logic [2:0]      bit_position_i,
  input  logic            suppress_zero_i,
  input  logic [3:0]      flags_in_i,
  output logic            valid_o,
  input  logic            stall_i,
  output ealu_pkg::prep_t prep_o
);
  import ealu_pkg::*;

  logic  valid_q;
  prep_t prep_d, prep_q;
  logic  hi_fix, lo_fix;
  op_e   op;

  // Decode carry-in and decimal adjust
  always_comb begin
    op     = op_e'(opcode_i);
    hi_fix = flags_in_i[FlagC];
    lo_fix = flags_in_i[FlagH];
    if (!flags_in_i[FlagN]) begin
      hi_fix = flags_in_i[FlagC] || (acc_in_i > DaaHiLimit);
      lo_fix = flags_in_i[FlagH] || (acc_in_i[3:0] > DaaLoLimit);
    end
    prep_d.op       = op;
    prep_d.acc      = acc_in_i;
    prep_d.pair     = pair_in_i;
    prep_d.val      = operand_byte_i;
    prep_d.word     = operand_word_i;
    prep_d.mask     = 8'h01 << bit_position_i;
    prep_d.noz      = suppress_zero_i;
    prep_d.flags    = flags_in_i;
    prep_d.cy       = ((op == OP_ADC) || (op == OP_SBC)) && flags_in_i[FlagC];
    prep_d.daa_corr = (hi_fix ? DaaHiCorr : 8'h00) | (lo_fix ? DaaLoCorr : 8'h00);
    prep_d.daa_c    = hi_fix;
  end

  // Hold while the next stage stalls on a full register
  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      prep_q <= prep_d;
    end
  end

  assign valid_o = valid_q;
  assign prep_o  = prep_q;

endmodule

// ----- rtl/ealu_arith.sv -----
// ----------------------------------------------------------------------------
// ALU arithmetic stage
// Adders, subtractors, rotates, shifts and bit operations per opcode.
// ----------------------------------------------------------------------------
module ealu_arith (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  ealu_pkg::prep_t  prep_i,
  output logic             valid_o,
  input  logic             stall_i,
  output ealu_pkg::arith_t arith_o
);
  import ealu_pkg::*;

  logic        valid_q;
  arith_t      arith_d, arith_q;
  logic [8:0]  sum9, diff9;
  logic [4:0]  hsum, hdiff;
  logic [16:0] sum17;
  logic [12:0] hsum13;
  logic [7:0]  v;
  logic        ci;

  // Shared adders
  always_comb begin
    v      = prep_i.val;
    ci     = prep_i.flags[FlagC];
    sum9   = {1'b0, prep_i.acc} + {1'b0, v} + {8'd0, prep_i.cy};
    diff9  = {1'b0, prep_i.acc} - {1'b0, v} - {8'd0, prep_i.cy};
    hsum   = {1'b0, prep_i.acc[3:0]} + {1'b0, v[3:0]} + {4'd0, prep_i.cy};
    hdiff  = {1'b0, prep_i.acc[3:0]} - {1'b0, v[3:0]} - {4'd0, prep_i.cy};
    sum17  = {1'b0, prep_i.pair} + {1'b0, prep_i.word};
    hsum13 = {1'b0, prep_i.pair[11:0]} + {1'b0, prep_i.word[11:0]};
  end

  // Select results and flag parts
  always_comb begin
    arith_d.acc      = prep_i.acc;
    arith_d.pair     = prep_i.pair;
    arith_d.byte_res = 8'h00;
    arith_d.word_res = 16'h0000;
    arith_d.zval     = 8'h00;
    arith_d.zsel     = Z_KEEP;
    arith_d.zin      = prep_i.flags[FlagZ];
    arith_d.n        = prep_i.flags[FlagN];
    arith_d.h        = prep_i.flags[FlagH];
    arith_d.c        = ci;
    case (prep_i.op)
      OP_ADD, OP_ADC: begin
        arith_d.acc  = sum9[7:0];
        arith_d.zval = sum9[7:0];
        arith_d.zsel = Z_TEST;
        arith_d.n    = 1'b0;
        arith_d.h    = hsum[4];
        arith_d.c    = sum9[8];
      end
      OP_SUB, OP_SBC, OP_CP: begin
        if (prep_i.op != OP_CP) begin
          arith_d.acc = diff9[7:0];
        end
        arith_d.zval = diff9[7:0];
        arith_d.zsel = Z_TEST;
        arith_d.n    = 1'b1;
        arith_d.h    = hdiff[4];
        arith_d.c    = diff9[8];
      end
      OP_AND: begin
        arith_d.acc  = prep_i.acc & v;
        arith_d.zval = prep_i.acc & v;
        arith_d.zsel = Z_TEST;
        arith_d.n    = 1'b0;
        arith_d.h    = 1'b1;
        arith_d.c    = 1'b0;
      end
      OP_OR: begin
        arith_d.acc  = prep_i.acc | v;
        arith_d.zval = prep_i.acc | v;
        arith_d.zsel = Z_TEST;
        arith_d.n    = 1'b0;
        arith_d.h    = 1'b0;
        arith_d.c    = 1'b0;
      end
      OP_XOR: begin
        arith_d.acc  = prep_i.acc ^ v;
        arith_d.zval = prep_i.acc ^ v;
        arith_d.zsel = Z_TEST;
        arith_d.n    = 1'b0;
        arith_d.h    = 1'b0;
        arith_d.c    = 1'b0;
      end
      OP_INC: begin
        arith_d.byte_res = v + 8'd1;
        arith_d.zval     = v + 8'd1;
        arith_d.zsel     = Z_TEST;
        arith_d.n        = 1'b0;
        arith_d.h        = (v[3:0] == 4'hF);
      end
      OP_DEC: begin
        arith_d.byte_res = v - 8'd1;
        arith_d.zval     = v - 8'd1;
        arith_d.zsel     = Z_TEST;
        arith_d.n        = 1'b1;
        arith_d.h        = (v[3:0] == 4'h0);
      end
      OP_ADD16: begin
        arith_d.pair = sum17[15:0];
        arith_d.n    = 1'b0;
        arith_d.h    = hsum13[12];
        arith_d.c    = sum17[16];
      end
      OP_INC16: begin
        arith_d.word_res = prep_i.word + 16'd1;
      end
      OP_DEC16: begin
        arith_d.word_res = prep_i.word - 16'd1;
      end
      OP_DAA: begin
        if (prep_i.flags[FlagN]) begin
          arith_d.acc  = prep_i.acc - prep_i.daa_corr;
          arith_d.zval = prep_i.acc - prep_i.daa_corr;
        end else begin
          arith_d.acc  = prep_i.acc + prep_i.daa_corr;
          arith_d.zval = prep_i.acc + prep_i.daa_corr;
        end
        arith_d.zsel = Z_TEST;
        arith_d.h    = 1'b0;
        arith_d.c    = prep_i.daa_c;
      end
      OP_RLC, OP_RL, OP_RRC, OP_RR: begin
        case (prep_i.op)
          OP_RLC:  arith_d.byte_res = {v[6:0], v[7]};
          OP_RL:   arith_d.byte_res = {v[6:0], ci};
          OP_RRC:  arith_d.byte_res = {v[0], v[7:1]};
          default: arith_d.byte_res = {ci, v[7:1]};
        endcase
        arith_d.zval = arith_d.byte_res;
        arith_d.zsel = prep_i.noz ? Z_CLEAR : Z_TEST;
        arith_d.n    = 1'b0;
        arith_d.h    = 1'b0;
        arith_d.c    = ((prep_i.op == OP_RLC) || (prep_i.op == OP_RL)) ? v[7] : v[0];
      end
      OP_SLA: begin
        arith_d.byte_res = {v[6:0], 1'b0};
        arith_d.zval     = {v[6:0], 1'b0};
        arith_d.zsel     = Z_TEST;
        arith_d.n        = 1'b0;
        arith_d.h        = 1'b0;
        arith_d.c        = v[7];
      end
      OP_SRA: begin
        arith_d.byte_res = {v[7], v[7:1]};
        arith_d.zval     = {v[7], v[7:1]};
        arith_d.zsel     = Z_TEST;
        arith_d.n        = 1'b0;
        arith_d.h        = 1'b0;
        arith_d.c        = v[0];
      end
      OP_SRL: begin
        arith_d.byte_res = {1'b0, v[7:1]};
        arith_d.zval     = {1'b0, v[7:1]};
        arith_d.zsel     = Z_TEST;
        arith_d.n        = 1'b0;
        arith_d.h        = 1'b0;
        arith_d.c        = v[0];
      end
      OP_BIT: begin
        arith_d.zval = {7'd0, |(v & prep_i.mask)};
        arith_d.zsel = Z_TEST;
        arith_d.n    = 1'b0;
        arith_d.h    = 1'b1;
      end
      OP_SET: begin
        arith_d.byte_res = v | prep_i.mask;
      end
      OP_RES: begin
        arith_d.byte_res = v & ~prep_i.mask;
      end
      OP_SWAP: begin
        arith_d.byte_res = {v[3:0], v[7:4]};
        arith_d.zval     = {v[3:0], v[7:4]};
        arith_d.zsel     = Z_TEST;
        arith_d.n        = 1'b0;
        arith_d.h        = 1'b0;
        arith_d.c        = 1'b0;
      end
      default: begin
        arith_d.zsel = Z_KEEP;
      end
    endcase
  end

  // Hold while the next stage stalls on a full register
  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      arith_q <= arith_d;
    end
  end

  assign valid_o = valid_q;
  assign arith_o = arith_q;

endmodule

// ----- rtl/ealu_flags.sv -----
// ----------------------------------------------------------------------------
// ALU flag stage
// Detects zero, assembles Z/N/H/C and holds the output register.
// ----------------------------------------------------------------------------
module ealu_flags (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  ealu_pkg::arith_t arith_i,
  output logic             valid_o,
  input  logic             stall_i,
  output logic [7:0]       acc_out_o,
  output logic [15:0]      pair_out_o,
  output logic [7:0]       byte_result_o,
  output logic [15:0]      word_result_o,
  output logic [3:0]       flags_out_o
);
  import ealu_pkg::*;

  logic        valid_q;
  logic        z;
  logic [3:0]  flags_d, flags_q;
  logic [7:0]  acc_q, byte_q;
  logic [15:0] pair_q, word_q;

  // Form the zero flag
  always_comb begin
    case (arith_i.zsel)
      Z_TEST:  z = (arith_i.zval == 8'h00);
      Z_KEEP:  z = arith_i.zin;
      Z_CLEAR: z = 1'b0;
      default: z = 1'b0;
    endcase
    flags_d = {z, arith_i.n, arith_i.h, arith_i.c};
  end

  // Hold the result while the consumer stalls
  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      acc_q   <= arith_i.acc;
      pair_q  <= arith_i.pair;
      byte_q  <= arith_i.byte_res;
      word_q  <= arith_i.word_res;
      flags_q <= flags_d;
    end
  end

  assign valid_o       = valid_q;
  assign acc_out_o     = acc_q;
  assign pair_out_o    = pair_q;
  assign byte_result_o = byte_q;
  assign word_result_o = word_q;
  assign flags_out_o   = flags_q;

endmodule

// ----- rtl/eight_bit_cpu_alu_with_flags.sv -----
// ----------------------------------------------------------------------------
// Eight-bit CPU ALU with flags
// Three-stage pipelined ALU: operand capture, arithmetic, flag assembly.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                 Payload
//  in       sink       in_valid_i / in_stall_o   opcode, acc, HL, operands, flags
//  out      source     out_valid_o / out_stall_i acc, HL, byte, word, flags
//
//  One transfer is taken every cycle unless a stall has backed up to the
//  input; there are three register stages (operand, arithmetic, flag/output).
//  Reset clears the stage valid bits only; payload registers are not reset.
//  A stall on the output holds each full stage in turn back to the input;
//  empty stages keep filling, so no transfer is lost or repeated.
// ----------------------------------------------------------------------------
module eight_bit_cpu_alu_with_flags (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [4:0]  opcode_i,
  input  logic [7:0]  acc_in_i,
  input  logic [15:0] pair_in_i,
  input  logic [7:0]  operand_byte_i,
  input  logic [15:0] operand_word_i,
  input  logic [2:0]  bit_position_i,
  input  logic        suppress_zero_i,
  input  logic [3:0]  flags_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  acc_out_o,
  output logic [15:0] pair_out_o,
  output logic [7:0]  byte_result_o,
  output logic [15:0] word_result_o,
  output logic [3:0]  flags_out_o
);
  import ealu_pkg::*;

  logic   prep_valid, prep_stall;
  logic   arith_valid, arith_stall;
  prep_t  prep;
  arith_t arith;

  // Capture operands and decode
  ealu_prep u_prep (
    .clk_i,
    .rst_ni,
    .valid_i         (in_valid_i),
    .stall_o         (in_stall_o),
    .opcode_i,
    .acc_in_i,
    .pair_in_i,
    .operand_byte_i,
    .operand_word_i,
    .bit_position_i,
    .suppress_zero_i,
    .flags_in_i,
    .valid_o         (prep_valid),
    .stall_i         (prep_stall),
    .prep_o          (prep)
  );

  // Compute results
  ealu_arith u_arith (
    .clk_i,
    .rst_ni,
    .valid_i (prep_valid),
    .stall_o (prep_stall),
    .prep_i  (prep),
    .valid_o (arith_valid),
    .stall_i (arith_stall),
    .arith_o (arith)
  );

  // Assemble flags and drive the output register
  ealu_flags u_flags (
    .clk_i,
    .rst_ni,
    .valid_i       (arith_valid),
    .stall_o       (arith_stall),
    .arith_i       (arith),
    .valid_o       (out_valid_o),
    .stall_i       (out_stall_i),
    .acc_out_o,
    .pair_out_o,
    .byte_result_o,
    .word_result_o,
    .flags_out_o
  );

endmodule

// ----- rtl/ealu_checker.sv -----
// ----------------------------------------------------------------------------
// ALU port checker
// Watches the top-level ports for reset, hold, latency and compare behavior.
// ----------------------------------------------------------------------------
`include "eight_bit_cpu_alu_with_flags_assert.svh"

module ealu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [4:0]  opcode_i,
  input logic [7:0]  acc_in_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  acc_out_o,
  input logic [3:0]  flags_out_o
);
  import ealu_pkg::*;

  logic in_xfer;
  logic cp_xfer;

  assign in_xfer = in_valid_i && !in_stall_o;
  assign cp_xfer = in_xfer && (opcode_i == OP_CP);

  // Leave reset with no result pending
  `EALU_ASSERT_ALWAYS(a_reset_empty, !rst_ni ##1 rst_ni |-> !out_valid_o,
    "result valid on leaving reset")

  // Stalled result holds
  `EALU_ASSERT(a_out_hold,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(flags_out_o) && $stable(acc_out_o),
    "stalled result changed")

  // An unstalled transfer reaches the output through the stages
  `EALU_ASSERT(a_latency, in_xfer ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o,
    "result missing after pipeline latency")

  // Compare keeps the accumulator and sets N
  `EALU_ASSERT(a_cp_keeps_acc,
    cp_xfer ##1 !out_stall_i ##1 !out_stall_i |=>
      acc_out_o == $past(acc_in_i, 3) && flags_out_o[FlagN],
    "compare altered accumulator or cleared N")

endmodule

bind eight_bit_cpu_alu_with_flags ealu_checker u_ealu_checker (.*);

// ----- sim/alu_result_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ALU result checker
// Watches both channels of the ALU, computes the expected result of every
// accepted operation and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module alu_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [4:0]  opcode_i,
  input  logic [7:0]  acc_in_i,
  input  logic [15:0] pair_in_i,
  input  logic [7:0]  operand_byte_i,
  input  logic [15:0] operand_word_i,
  input  logic [2:0]  bit_position_i,
  input  logic        suppress_zero_i,
  input  logic [3:0]  flags_in_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  acc_out_i,
  input  logic [15:0] pair_out_i,
  input  logic [7:0]  byte_result_i,
  input  logic [15:0] word_result_i,
  input  logic [3:0]  flags_out_i,
  output int          fail_count_o,
  output int          pending_o
);
  import ealu_pkg::*;

  typedef struct packed {
    logic [7:0]  acc;
    logic [15:0] pair;
    logic [7:0]  byte_res;
    logic [15:0] word_res;
    logic [3:0]  flags;
  } alu_result_t;

  alu_result_t expected_results_q[$];

  function automatic logic [3:0] pack_flags(logic z, logic n, logic h, logic c);
    logic [3:0] fl;
    fl        = '0;
    fl[FlagZ] = z;
    fl[FlagN] = n;
    fl[FlagH] = h;
    fl[FlagC] = c;
    return fl;
  endfunction

  // Compute the full ALU result of one operation
  function automatic alu_result_t predict_alu(logic [4:0] op, logic [7:0] a, logic [15:0] hl,
                                              logic [7:0] v, logic [15:0] w, logic [2:0] pos,
                                              logic noz, logic [3:0] f);
    alu_result_t r;
    logic [8:0]  s9;
    logic [4:0]  s5;
    logic [16:0] s17;
    logic [12:0] s13;
    logic        cy;
    logic        c_out;
    logic [7:0]  corr;
    r.acc      = a;
    r.pair     = hl;
    r.byte_res = '0;
    r.word_res = '0;
    r.flags    = f;
    case (op)
      OP_ADD, OP_ADC: begin
        cy      = (op == OP_ADC) && f[FlagC];
        s9      = {1'b0, a} + {1'b0, v} + {8'b0, cy};
        s5      = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'b0, cy};
        r.acc   = s9[7:0];
        r.flags = pack_flags(s9[7:0] == 8'h00, 1'b0, s5[4], s9[8]);
      end
      OP_SUB, OP_SBC, OP_CP: begin
        // Borrow shows up as the sign bit of the widened difference
        cy      = (op == OP_SBC) && f[FlagC];
        s9      = {1'b0, a} - {1'b0, v} - {8'b0, cy};
        s5      = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'b0, cy};
        if (op != OP_CP) r.acc = s9[7:0];
        r.flags = pack_flags(s9[7:0] == 8'h00, 1'b1, s5[4], s9[8]);
      end
      OP_AND: begin
        r.acc   = a & v;
        r.flags = pack_flags(r.acc == 8'h00, 1'b0, 1'b1, 1'b0);
      end
      OP_OR: begin
        r.acc   = a | v;
        r.flags = pack_flags(r.acc == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      OP_XOR: begin
        r.acc   = a ^ v;
        r.flags = pack_flags(r.acc == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      OP_INC: begin
        r.byte_res = v + 8'h01;
        r.flags    = pack_flags(r.byte_res == 8'h00, 1'b0, v[3:0] == 4'hF, f[FlagC]);
      end
      OP_DEC: begin
        r.byte_res = v - 8'h01;
        r.flags    = pack_flags(r.byte_res == 8'h00, 1'b1, v[3:0] == 4'h0, f[FlagC]);
      end
      OP_ADD16: begin
        s17     = {1'b0, hl} + {1'b0, w};
        s13     = {1'b0, hl[11:0]} + {1'b0, w[11:0]};
        r.pair  = s17[15:0];
        r.flags = pack_flags(f[FlagZ], 1'b0, s13[12], s17[16]);
      end
      OP_INC16: r.word_res = w + 16'h0001;
      OP_DEC16: r.word_res = w - 16'h0001;
      OP_DAA: begin
        // Correct after a BCD add or subtract, depending on N
        corr  = '0;
        c_out = f[FlagC];
        if (!f[FlagN]) begin
          if (f[FlagC] || a > DaaHiLimit) begin
            corr  = corr | DaaHiCorr;
            c_out = 1'b1;
          end
          if (f[FlagH] || a[3:0] > DaaLoLimit) corr = corr | DaaLoCorr;
          r.acc = a + corr;
        end else begin
          if (f[FlagC]) corr = corr | DaaHiCorr;
          if (f[FlagH]) corr = corr | DaaLoCorr;
          r.acc = a - corr;
        end
        r.flags = pack_flags(r.acc == 8'h00, f[FlagN], 1'b0, c_out);
      end
      OP_RLC: begin
        r.byte_res = {v[6:0], v[7]};
        r.flags    = pack_flags(!noz && r.byte_res == 8'h00, 1'b0, 1'b0, v[7]);
      end
      OP_RL: begin
        r.byte_res = {v[6:0], f[FlagC]};
        r.flags    = pack_flags(!noz && r.byte_res == 8'h00, 1'b0, 1'b0, v[7]);
      end
      OP_RRC: begin
        r.byte_res = {v[0], v[7:1]};
        r.flags    = pack_flags(!noz && r.byte_res == 8'h00, 1'b0, 1'b0, v[0]);
      end
      OP_RR: begin
        r.byte_res = {f[FlagC], v[7:1]};
        r.flags    = pack_flags(!noz && r.byte_res == 8'h00, 1'b0, 1'b0, v[0]);
      end
      OP_SLA: begin
        r.byte_res = {v[6:0], 1'b0};
        r.flags    = pack_flags(r.byte_res == 8'h00, 1'b0, 1'b0, v[7]);
      end
      OP_SRA: begin
        r.byte_res = {v[7], v[7:1]};
        r.flags    = pack_flags(r.byte_res == 8'h00, 1'b0, 1'b0, v[0]);
      end
      OP_SRL: begin
        r.byte_res = {1'b0, v[7:1]};
        r.flags    = pack_flags(r.byte_res == 8'h00, 1'b0, 1'b0, v[0]);
      end
      OP_BIT:  r.flags = pack_flags(!v[pos], 1'b0, 1'b1, f[FlagC]);
      OP_SET:  r.byte_res = v | (8'h01 << pos);
      OP_RES:  r.byte_res = v & ~(8'h01 << pos);
      OP_SWAP: begin
        r.byte_res = {v[3:0], v[7:4]};
        r.flags    = pack_flags(r.byte_res == 8'h00, 1'b0, 1'b0, 1'b0);
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string field, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
      fail_count_o++;
    end
  endtask

  // Compare result transfers, then queue the prediction for a new operation
  always @(posedge clk_i) begin : watch
    alu_result_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results_q.size() == 0) begin
          $error("result transfer with no operation outstanding");
          fail_count_o++;
        end else begin
          want = expected_results_q.pop_front();
          check_field("acc_out", 16'(want.acc), 16'(acc_out_i));
          check_field("pair_out", want.pair, pair_out_i);
          check_field("byte_result", 16'(want.byte_res), 16'(byte_result_i));
          check_field("word_result", want.word_res, word_result_i);
          check_field("flags_out", 16'(want.flags), 16'(flags_out_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_results_q.push_back(predict_alu(opcode_i, acc_in_i, pair_in_i, operand_byte_i,
                                                 operand_word_i, bit_position_i, suppress_zero_i,
                                                 flags_in_i));
      end
      pending_o = expected_results_q.size();
    end
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ALU testbench top
// Drives directed and random operations into the pipelined ALU with bursty
// input traffic and a patterned output stall, and reports the verdict from
// the result checker.
// ----------------------------------------------------------------------------
module tb_top;
  import ealu_pkg::*;

  localparam int         ClkPeriod     = 10;
  localparam int         RandomItems   = 1500;
  localparam int         DrainInterval = 400;
  localparam int         IdleLimit     = 2000;
  localparam logic [4:0] OpUnusedFirst = 5'd25;
  localparam logic [4:0] OpUnusedLast  = 5'd31;

  typedef enum logic [1:0] {
    StallNone,
    StallLight,
    StallHeavy,
    StallPeriodic
  } stall_mode_e;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [4:0]  opcode_i        = '0;
  logic [7:0]  acc_in_i        = '0;
  logic [15:0] pair_in_i       = '0;
  logic [7:0]  operand_byte_i  = '0;
  logic [15:0] operand_word_i  = '0;
  logic [2:0]  bit_position_i  = '0;
  logic        suppress_zero_i = 1'b0;
  logic [3:0]  flags_in_i      = '0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [7:0]  acc_out_o;
  logic [15:0] pair_out_o;
  logic [7:0]  byte_result_o;
  logic [15:0] word_result_o;
  logic [3:0]  flags_out_o;

  int          fail_count;
  int          pending;
  int          burst_left      = 0;
  int          stall_left      = 0;
  stall_mode_e stall_mode      = StallNone;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  eight_bit_cpu_alu_with_flags dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .opcode_i,
    .acc_in_i,
    .pair_in_i,
    .operand_byte_i,
    .operand_word_i,
    .bit_position_i,
    .suppress_zero_i,
    .flags_in_i,
    .out_valid_o,
    .out_stall_i,
    .acc_out_o,
    .pair_out_o,
    .byte_result_o,
    .word_result_o,
    .flags_out_o
  );

  alu_result_checker u_checker (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_i     (in_stall_o),
    .opcode_i,
    .acc_in_i,
    .pair_in_i,
    .operand_byte_i,
    .operand_word_i,
    .bit_position_i,
    .suppress_zero_i,
    .flags_in_i,
    .out_valid_i    (out_valid_o),
    .out_stall_i,
    .acc_out_i      (acc_out_o),
    .pair_out_i     (pair_out_o),
    .byte_result_i  (byte_result_o),
    .word_result_i  (word_result_o),
    .flags_out_i    (flags_out_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // Stall the result channel in phases: none, light, heavy, periodic
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      StallNone:  out_stall_i <= 1'b0;
      StallLight: out_stall_i <= ($urandom_range(0, 3) == 0);
      StallHeavy: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:    out_stall_i <= (stall_left[1:0] == 2'd0);
    endcase
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h0FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Present one operation and hold it until the ALU takes the transfer
  task automatic push_op(input logic [4:0] op, input logic [7:0] acc, input logic [15:0] hl,
                         input logic [7:0] opb, input logic [15:0] opw, input logic [2:0] pos,
                         input logic noz, input logic [3:0] fl);
    int gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
      if ($urandom_range(0, 15) == 0) gap = $urandom_range(20, 40);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    opcode_i        <= op;
    acc_in_i        <= acc;
    pair_in_i       <= hl;
    operand_byte_i  <= opb;
    operand_word_i  <= opw;
    bit_position_i  <= pos;
    suppress_zero_i <= noz;
    flags_in_i      <= fl;
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Hold off the sender until every outstanding result has come back
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // End the run when no transfer happens for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    wait (rst_ni);
    while (idle_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("eight_bit_cpu_alu_with_flags: mismatch");
    $finish;
  end

  initial begin : stimulus
    int          op_items;
    logic [4:0]  op;
    op_items = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: field extremes, every operation and the flag corner cases
    push_op(OP_ADD,   8'hFF, 16'h0000, 8'h01, 16'h0000, 3'd0, 1'b0, 4'h0);
    push_op(OP_ADC,   8'h0F, 16'hFFFF, 8'h00, 16'hFFFF, 3'd7, 1'b1, 4'h1);
    push_op(OP_SUB,   8'h00, 16'h0000, 8'h01, 16'h0000, 3'd0, 1'b0, 4'hF);
    push_op(OP_SBC,   8'h10, 16'h0000, 8'h0F, 16'h0000, 3'd0, 1'b0, 4'h1);
    push_op(OP_AND,   8'hF0, 16'h0000, 8'h0F, 16'h0000, 3'd0, 1'b0, 4'h0);
    push_op(OP_OR,    8'h00, 16'h0000, 8'h00, 16'h0000, 3'd0, 1'b0, 4'hF);
    push_op(OP_XOR,   8'hFF, 16'h0000, 8'hFF, 16'h0000, 3'd0, 1'b0, 4'h0);
    push_op(OP_CP,    8'h42, 16'h0000, 8'h42, 16'h0000, 3'd0, 1'b0, 4'h0);
    // inc from a full low nibble and dec from an empty one carry into H
    push_op(OP_INC,   8'h00, 16'h0000, 8'hFF, 16'h0000, 3'd0, 1'b0, 4'h1);
    push_op(OP_DEC,   8'h00, 16'h0000, 8'h00, 16'h0000, 3'd0, 1'b0, 4'h0);
    // add16 keeps Z, H from bit 11, C from bit 15
    push_op(OP_ADD16, 8'h00, 16'hFFFF, 8'h00, 16'h0001, 3'd0, 1'b0, 4'h8);
    push_op(OP_ADD16, 8'h00, 16'h0FFF, 8'h00, 16'h0001, 3'd0, 1'b0, 4'h0);
    push_op(OP_INC16, 8'h00, 16'h0000, 8'h00, 16'hFFFF, 3'd0, 1'b0, 4'hF);
    push_op(OP_DEC16, 8'h00, 16'h0000, 8'h00, 16'h0000, 3'd0, 1'b0, 4'h0);
    // daa after an add wraps to zero, after a subtract with H and C set
    push_op(OP_DAA,   8'h9A, 16'h0000, 8'h00, 16'h0000, 3'd0, 1'b0, 4'h0);
    push_op(OP_DAA,   8'h00, 16'h0000, 8'h00, 16'h0000, 3'd0, 1'b0, 4'h7);
    // zero suppress on the rotate forms, but not on sla
    push_op(OP_RLC,   8'h00, 16'h0000, 8'h00, 16'h0000, 3'd0, 1'b1, 4'h0);
    push_op(OP_RL,    8'h00, 16'h0000, 8'h80, 16'h0000, 3'd0, 1'b0, 4'h0);
    push_op(OP_RRC,   8'h00, 16'h0000, 8'h01, 16'h0000, 3'd0, 1'b0, 4'h0);
    push_op(OP_RR,    8'h00, 16'h0000, 8'h01, 16'h0000, 3'd0, 1'b1, 4'h1);
    push_op(OP_SLA,   8'h00, 16'h0000, 8'h80, 16'h0000, 3'd0, 1'b1, 4'h0);
    push_op(OP_SRA,   8'h00, 16'h0000, 8'h81, 16'h0000, 3'd0, 1'b0, 4'h0);
    push_op(OP_SRL,   8'h00, 16'h0000, 8'h01, 16'h0000, 3'd0, 1'b0, 4'h0);
    push_op(OP_BIT,   8'h00, 16'h0000, 8'h7F, 16'h0000, 3'd7, 1'b0, 4'h1);
    push_op(OP_SET,   8'h00, 16'h0000, 8'h00, 16'h0000, 3'd7, 1'b0, 4'hA);
    push_op(OP_RES,   8'h00, 16'h0000, 8'hFF, 16'h0000, 3'd0, 1'b0, 4'h5);
    push_op(OP_SWAP,  8'h00, 16'h0000, 8'h00, 16'h0000, 3'd0, 1'b0, 4'hF);
    push_op(OpUnusedLast, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF, 3'd7, 1'b1, 4'hF);
    wait_drained();

    // Random operations; unused codes mixed in but not counted
    while (op_items < RandomItems) begin
      if ($urandom_range(0, 7) == 0) op = 5'($urandom_range(OpUnusedFirst, OpUnusedLast));
      else op = 5'($urandom_range(OP_ADD, OP_SWAP));
      push_op(op, pick_byte(), pick_word(), pick_byte(), pick_word(),
              3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
      if (op <= OP_SWAP) begin
        op_items++;
        if (op_items % DrainInterval == 0) wait_drained();
      end
    end

    // Let the pipeline empty, then give the verdict
    wait_drained();
    repeat (10) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("eight_bit_cpu_alu_with_flags: match");
    end else begin
      $display("eight_bit_cpu_alu_with_flags: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/ealu_pkg.sv
rtl/ealu_prep.sv
rtl/ealu_arith.sv
rtl/ealu_flags.sv
rtl/eight_bit_cpu_alu_with_flags.sv
rtl/ealu_checker.sv
sim/alu_result_checker.sv
sim/tb_top.sv
